// ===== hw/rtl/pts_pkg.sv =====
package pts_pkg;

   localparam int MaxTasks = 16;
   localparam int SlotW = $clog2(MaxTasks);
   localparam int CntW = $clog2(MaxTasks + 1);

   typedef logic [SlotW-1:0] slot_type;
   typedef logic [CntW-1:0] cnt_type;

   typedef enum logic [1:0] {
      OP_YIELD = 2'd0,
      OP_START = 2'd1,
      OP_EXIT  = 2'd2,
      OP_WAIT  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_FREE    = 3'd0,
      ST_READY   = 3'd1,
      ST_RUNNING = 3'd2,
      ST_ZOMBIE  = 3'd3,
      ST_WAITING = 3'd4
   } slot_state_type;

   typedef enum logic [2:0] {
      RS_DONE        = 3'd0,
      RS_EMPTY       = 3'd1,
      RS_NO_SLOT     = 3'd2,
      RS_UNSUPPORTED = 3'd3,
      RS_REFUSED     = 3'd4,
      RS_BLOCKED     = 3'd5,
      RS_NONE_YET    = 3'd6
   } rsp_status_type;

   localparam logic signed [15:0] IdleTaskPriority = -16'sd32767;
   localparam logic [15:0] LastId = 16'd32767;
   localparam int CodeShift = 8;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [15:0] priority_req;
      logic signed [15:0] target_pid;
      logic [7:0]         exit_code;
      logic               no_hang;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [14:0] running_pid;
      logic [14:0] returned_pid;
      logic [15:0] wait_status;
   } rsp_type;

endpackage

// ===== hw/rtl/priority_task_scheduler_top.sv =====
// Task scheduler: each request word (yield, start, exit, wait) yields one
// response word. A request is handled by a sequencer that walks the slot
// table and the ready, zombie and waiter lists one entry per cycle; the slot
// table and the zombie and waiter lists go through a single shared compare,
// and a list insert or removal shifts one entry per cycle.
// req_ready is low while a word is in work; the response is held in an output
// register until taken, and the next request is accepted alongside it.
module priority_task_scheduler_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pts_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pts_pkg::rsp_type rsp
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_SCAN   = 9'b000000010,
      S_DROP   = 9'b000000100,
      S_PFIND  = 9'b000001000,
      S_PSHIFT = 9'b000010000,
      S_NEXT   = 9'b000100000,
      S_PUT2   = 9'b001000000,
      S_DONE   = 9'b010000000,
      S_WAKE   = 9'b100000000
   } fsm_type;

   // List selectors for the shared scan/drop machinery.
   localparam logic [1:0] L_READY = 2'd0, L_ZOMB = 2'd1, L_WAIT = 2'd2, L_SLOT = 2'd3;

   pts_pkg::slot_state_type st_ff [pts_pkg::MaxTasks];
   logic [14:0]        id_ff  [pts_pkg::MaxTasks];
   logic signed [15:0] pri_ff [pts_pkg::MaxTasks];
   logic signed [15:0] par_ff [pts_pkg::MaxTasks];
   logic [7:0]         code_ff [pts_pkg::MaxTasks];
   logic signed [15:0] wt_ff  [pts_pkg::MaxTasks];
   pts_pkg::slot_type  rdy_ff [pts_pkg::MaxTasks];
   pts_pkg::slot_type  zl_ff  [pts_pkg::MaxTasks];
   pts_pkg::slot_type  wl_ff  [pts_pkg::MaxTasks];
   pts_pkg::cnt_type   rcnt_ff, zcnt_ff, wcnt_ff;
   pts_pkg::slot_type  cur_ff;
   logic [15:0]        idc_ff;

   fsm_type            fsm_ff;
   pts_pkg::req_type   req_ff;
   pts_pkg::cnt_type   idx_ff;
   logic [1:0]         lst_ff;
   pts_pkg::slot_type  hit_ff;  // slot found by a scan, or the insert position in the ready list
   pts_pkg::slot_type  put_ff;  // slot being inserted into the ready list
   pts_pkg::slot_type  wake_ff;
   logic               next_pend_ff;
   logic [2:0]         stat_ff;
   logic [14:0]        ret_ff;
   logic [15:0]        ws_ff;
   logic               rv_ff;
   pts_pkg::rsp_type   rsp_ff;
   logic               rsp_load;

   assign req_ready = (fsm_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp = rsp_ff;
   assign rsp_load = (fsm_ff == S_DONE) && (!rv_ff || rsp_ready);

   pts_pkg::slot_type cur_slot, scan_slot;
   logic [14:0] cur_id;
   logic scan_end, scan_hit;

   always_comb begin
      cur_id = id_ff[cur_ff];
      cur_slot = cur_ff;
      unique case (lst_ff)
         L_READY: begin
            scan_slot = rdy_ff[idx_ff[pts_pkg::SlotW-1:0]];
            scan_end = (idx_ff >= rcnt_ff);
         end
         L_ZOMB: begin
            scan_slot = zl_ff[idx_ff[pts_pkg::SlotW-1:0]];
            scan_end = (idx_ff >= zcnt_ff);
         end
         L_WAIT: begin
            scan_slot = wl_ff[idx_ff[pts_pkg::SlotW-1:0]];
            scan_end = (idx_ff >= wcnt_ff);
         end
         default: begin
            scan_slot = idx_ff[pts_pkg::SlotW-1:0];
            scan_end = (idx_ff == pts_pkg::cnt_type'(pts_pkg::MaxTasks));
         end
      endcase
      // One shared compare, its meaning chosen by the operation.
      scan_hit = 1'b0;
      unique case (pts_pkg::op_type'(req_ff.operation))
         pts_pkg::OP_START: scan_hit = (st_ff[scan_slot] == pts_pkg::ST_FREE);
         pts_pkg::OP_EXIT: scan_hit =
            (wt_ff[scan_slot] > 16'sd0 && wt_ff[scan_slot] == $signed({1'b0, cur_id})) ||
            (wt_ff[scan_slot] == -16'sd1 && $signed({1'b0, id_ff[scan_slot]}) == par_ff[cur_slot]);
         pts_pkg::OP_WAIT: scan_hit = (req_ff.target_pid == -16'sd1) ?
            (par_ff[scan_slot] == $signed({1'b0, cur_id})) :
            ($signed({1'b0, id_ff[scan_slot]}) == req_ff.target_pid);
         default: scan_hit = 1'b0;
      endcase
   end

   pts_pkg::slot_type ix;
   assign ix = idx_ff[pts_pkg::SlotW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= S_IDLE;
         rv_ff <= 1'b0;
         for (int i = 0; i < pts_pkg::MaxTasks; i++) begin
            if (i == 0) st_ff[i] <= pts_pkg::ST_RUNNING;
            else if (i == 1) st_ff[i] <= pts_pkg::ST_READY;
            else st_ff[i] <= pts_pkg::ST_FREE;
         end
         id_ff[0] <= 15'd0;
         id_ff[1] <= 15'd1;
         pri_ff[0] <= 16'sd0;
         pri_ff[1] <= pts_pkg::IdleTaskPriority;
         par_ff[0] <= -16'sd1;
         par_ff[1] <= 16'sd0;
         rdy_ff[0] <= pts_pkg::slot_type'(1);
         rcnt_ff <= pts_pkg::cnt_type'(1);
         zcnt_ff <= '0;
         wcnt_ff <= '0;
         cur_ff <= '0;
         idc_ff <= 16'd2;
      end else begin
         if (rsp_load) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
         unique case (fsm_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff <= req;
                  ret_ff <= '0;
                  ws_ff <= '0;
                  idx_ff <= '0;
                  next_pend_ff <= 1'b0;
                  unique case (pts_pkg::op_type'(req.operation))
                     pts_pkg::OP_YIELD: begin
                        if (rcnt_ff == '0) begin
                           stat_ff <= pts_pkg::RS_EMPTY;
                           fsm_ff <= S_DONE;
                        end else begin
                           stat_ff <= pts_pkg::RS_DONE;
                           fsm_ff <= S_NEXT;
                        end
                     end
                     pts_pkg::OP_START: begin
                        stat_ff <= pts_pkg::RS_DONE;
                        lst_ff <= L_SLOT;
                        fsm_ff <= S_SCAN;
                     end
                     pts_pkg::OP_EXIT: begin
                        if (id_ff[cur_ff] == 15'd0) begin
                           stat_ff <= pts_pkg::RS_REFUSED;
                           fsm_ff <= S_DONE;
                        end else begin
                           stat_ff <= pts_pkg::RS_DONE;
                           lst_ff <= L_WAIT;
                           fsm_ff <= S_SCAN;
                        end
                     end
                     default: begin
                        if (req.target_pid < -16'sd1) begin
                           stat_ff <= pts_pkg::RS_UNSUPPORTED;
                           fsm_ff <= S_DONE;
                        end else begin
                           stat_ff <= pts_pkg::RS_DONE;
                           lst_ff <= L_ZOMB;
                           fsm_ff <= S_SCAN;
                        end
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (scan_end) begin
                  // No match found.
                  unique case (pts_pkg::op_type'(req_ff.operation))
                     pts_pkg::OP_START: begin
                        stat_ff <= pts_pkg::RS_NO_SLOT;
                        fsm_ff <= S_DONE;
                     end
                     pts_pkg::OP_EXIT: begin
                        if (rcnt_ff == '0) begin
                           stat_ff <= pts_pkg::RS_EMPTY;
                           fsm_ff <= S_DONE;
                        end else begin
                           st_ff[cur_ff] <= pts_pkg::ST_ZOMBIE;
                           code_ff[cur_ff] <= req_ff.exit_code;
                           zl_ff[zcnt_ff[pts_pkg::SlotW-1:0]] <= cur_ff;
                           zcnt_ff <= zcnt_ff + 1'b1;
                           fsm_ff <= S_NEXT;
                        end
                     end
                     default: begin
                        if (req_ff.no_hang) begin
                           stat_ff <= pts_pkg::RS_NONE_YET;
                           fsm_ff <= S_DONE;
                        end else if (rcnt_ff == '0) begin
                           stat_ff <= pts_pkg::RS_EMPTY;
                           fsm_ff <= S_DONE;
                        end else begin
                           st_ff[cur_ff] <= pts_pkg::ST_WAITING;
                           wt_ff[cur_ff] <= req_ff.target_pid;
                           wl_ff[wcnt_ff[pts_pkg::SlotW-1:0]] <= cur_ff;
                           wcnt_ff <= wcnt_ff + 1'b1;
                           stat_ff <= pts_pkg::RS_BLOCKED;
                           fsm_ff <= S_NEXT;
                        end
                     end
                  endcase
               end else if (scan_hit) begin
                  hit_ff <= scan_slot;
                  unique case (pts_pkg::op_type'(req_ff.operation))
                     pts_pkg::OP_START: begin
                        if (idc_ff > pts_pkg::LastId) begin
                           stat_ff <= pts_pkg::RS_NO_SLOT;
                           fsm_ff <= S_DONE;
                        end else begin
                           id_ff[scan_slot] <= idc_ff[14:0];
                           idc_ff <= idc_ff + 16'd1;
                           par_ff[scan_slot] <= $signed({1'b0, cur_id});
                           pri_ff[scan_slot] <= req_ff.priority_req;
                           code_ff[scan_slot] <= '0;
                           ret_ff <= idc_ff[14:0];
                           put_ff <= scan_slot;
                           idx_ff <= '0;
                           fsm_ff <= S_PFIND;
                        end
                     end
                     pts_pkg::OP_EXIT: begin
                        st_ff[cur_ff] <= pts_pkg::ST_ZOMBIE;
                        code_ff[cur_ff] <= req_ff.exit_code;
                        zl_ff[zcnt_ff[pts_pkg::SlotW-1:0]] <= cur_ff;
                        zcnt_ff <= zcnt_ff + 1'b1;
                        wake_ff <= scan_slot;
                        fsm_ff <= S_DROP;
                     end
                     default: begin
                        ret_ff <= id_ff[scan_slot];
                        ws_ff <= 16'({code_ff[scan_slot], 8'd0});
                        st_ff[scan_slot] <= pts_pkg::ST_FREE;
                        fsm_ff <= S_DROP;
                     end
                  endcase
               end else idx_ff <= idx_ff + 1'b1;
            end
            S_DROP: begin
               // Close the gap at idx, one entry per cycle.
               unique case (lst_ff)
                  L_READY: begin
                     if (idx_ff + 1'b1 < rcnt_ff) begin
                        rdy_ff[ix] <= rdy_ff[ix + 1'b1];
                        idx_ff <= idx_ff + 1'b1;
                     end else begin
                        rcnt_ff <= rcnt_ff - 1'b1;
                        fsm_ff <= S_PUT2;
                     end
                  end
                  L_ZOMB: begin
                     if (idx_ff + 1'b1 < zcnt_ff) begin
                        zl_ff[ix] <= zl_ff[ix + 1'b1];
                        idx_ff <= idx_ff + 1'b1;
                     end else begin
                        zcnt_ff <= zcnt_ff - 1'b1;
                        fsm_ff <= S_DONE;
                     end
                  end
                  default: begin
                     if (idx_ff + 1'b1 < wcnt_ff) begin
                        wl_ff[ix] <= wl_ff[ix + 1'b1];
                        idx_ff <= idx_ff + 1'b1;
                     end else begin
                        wcnt_ff <= wcnt_ff - 1'b1;
                        fsm_ff <= S_WAKE;
                     end
                  end
               endcase
            end
            S_WAKE: begin
               put_ff <= wake_ff;
               next_pend_ff <= 1'b1;
               idx_ff <= '0;
               fsm_ff <= S_PFIND;
            end
            S_PFIND: begin
               if (idx_ff < rcnt_ff && pri_ff[rdy_ff[ix]] >= pri_ff[put_ff]) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  hit_ff <= ix;
                  idx_ff <= rcnt_ff;
                  fsm_ff <= S_PSHIFT;
               end
            end
            S_PSHIFT: begin
               if (idx_ff > pts_pkg::cnt_type'(hit_ff)) begin
                  rdy_ff[ix] <= rdy_ff[ix - 1'b1];
                  idx_ff <= idx_ff - 1'b1;
               end else begin
                  rdy_ff[hit_ff] <= put_ff;
                  rcnt_ff <= rcnt_ff + 1'b1;
                  st_ff[put_ff] <= pts_pkg::ST_READY;
                  if (next_pend_ff) begin
                     next_pend_ff <= 1'b0;
                     fsm_ff <= S_NEXT;
                  end else fsm_ff <= S_DONE;
               end
            end
            S_NEXT: begin
               // Pop the ready head; previous task requeues if still running.
               wake_ff <= rdy_ff[0];
               lst_ff <= L_READY;
               idx_ff <= '0;
               fsm_ff <= S_DROP;
            end
            S_PUT2: begin
               st_ff[wake_ff] <= pts_pkg::ST_RUNNING;
               cur_ff <= wake_ff;
               if (st_ff[cur_ff] == pts_pkg::ST_RUNNING && cur_ff != wake_ff) begin
                  put_ff <= cur_ff;
                  idx_ff <= '0;
                  fsm_ff <= S_PFIND;
               end else fsm_ff <= S_DONE;
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_ff.status <= stat_ff;
                  rsp_ff.running_pid <= id_ff[cur_ff];
                  rsp_ff.returned_pid <= ret_ff;
                  rsp_ff.wait_status <= ws_ff;
                  fsm_ff <= S_IDLE;
               end
            end
            default: fsm_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_cur_running: assert property (@(posedge clock) disable iff (reset)
      fsm_ff == S_IDLE |-> st_ff[cur_ff] == pts_pkg::ST_RUNNING)
      else $error("current slot not running");
   a_ready_bound: assert property (@(posedge clock) disable iff (reset)
      rcnt_ff <= pts_pkg::cnt_type'(pts_pkg::MaxTasks))
      else $error("ready count overflow");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted while busy");
`endif

endmodule

// ===== tb/sv/priority_task_scheduler_top_test.sv =====
module priority_task_scheduler_top_test;

   localparam int NTasks = pts_pkg::MaxTasks;
   localparam int StallLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pts_pkg::req_type req = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pts_pkg::rsp_type rsp;

   priority_task_scheduler_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req(req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
   );

   always #10 clock = ~clock;

   // Scheduler shadow state.
   pts_pkg::slot_state_type sh_state[NTasks];
   logic [14:0] sh_id[NTasks];
   int sh_prio[NTasks];
   int sh_parent[NTasks];
   logic [7:0] sh_code[NTasks];
   int sh_target[NTasks];
   int ready_q[$];
   int zombie_q[$];
   int waiter_q[$];
   int cur_slot;
   int next_id;

   pts_pkg::rsp_type expected_words[$];
   int errors = 0;
   int idle_cycles = 0;

   task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic void shadow_reset();
      for (int i = 0; i < NTasks; i++) begin
         sh_state[i] = pts_pkg::ST_FREE;
         sh_id[i] = '0;
         sh_prio[i] = 0;
         sh_parent[i] = 0;
         sh_code[i] = '0;
         sh_target[i] = 0;
      end
      sh_state[0] = pts_pkg::ST_RUNNING;
      sh_parent[0] = -1;
      sh_state[1] = pts_pkg::ST_READY;
      sh_id[1] = 1;
      sh_prio[1] = pts_pkg::IdleTaskPriority;
      ready_q = {1};
      zombie_q = {};
      waiter_q = {};
      cur_slot = 0;
      next_id = 2;
   endfunction

   function automatic void ready_insert(input int s);
      int pos;
      pos = 0;
      while (pos < ready_q.size() && sh_prio[ready_q[pos]] >= sh_prio[s]) pos++;
      ready_q.insert(pos, s);
      sh_state[s] = pts_pkg::ST_READY;
   endfunction

   function automatic void switch_to_head();
      int prev;
      int nxt;
      if (ready_q.size() == 0) return;
      prev = cur_slot;
      nxt = ready_q.pop_front();
      cur_slot = nxt;
      if (sh_state[prev] == pts_pkg::ST_RUNNING) ready_insert(prev);
      sh_state[nxt] = pts_pkg::ST_RUNNING;
   endfunction

   function automatic pts_pkg::rsp_type schedule(input pts_pkg::req_type r);
      pts_pkg::rsp_type o;
      int c;
      int s;
      int w;
      int z;
      int t;
      int tgt;
      o = '0;
      o.status = pts_pkg::RS_DONE;
      c = cur_slot;
      tgt = int'(r.target_pid);
      case (pts_pkg::op_type'(r.operation))
         pts_pkg::OP_YIELD: begin
            if (ready_q.size() == 0) o.status = pts_pkg::RS_EMPTY;
            else switch_to_head();
         end
         pts_pkg::OP_START: begin
            s = -1;
            for (int i = 0; i < NTasks; i++)
               if (s < 0 && sh_state[i] == pts_pkg::ST_FREE) s = i;
            if (s < 0 || next_id > int'(pts_pkg::LastId)) begin
               o.status = pts_pkg::RS_NO_SLOT;
            end else begin
               sh_id[s] = next_id[14:0];
               next_id++;
               sh_parent[s] = int'(sh_id[c]);
               sh_prio[s] = int'(r.priority_req);
               sh_code[s] = '0;
               ready_insert(s);
               o.returned_pid = sh_id[s];
            end
         end
         pts_pkg::OP_EXIT: begin
            if (sh_id[c] == 0) begin
               o.status = pts_pkg::RS_REFUSED;
            end else begin
               w = -1;
               for (int i = 0; i < waiter_q.size(); i++) begin
                  t = sh_target[waiter_q[i]];
                  if (w < 0 && ((t > 0 && t == int'(sh_id[c])) ||
                      (t == -1 && int'(sh_id[waiter_q[i]]) == sh_parent[c]))) w = i;
               end
               if (w < 0 && ready_q.size() == 0) begin
                  o.status = pts_pkg::RS_EMPTY;
               end else begin
                  sh_state[c] = pts_pkg::ST_ZOMBIE;
                  sh_code[c] = r.exit_code;
                  zombie_q.push_back(c);
                  if (w >= 0) begin
                     s = waiter_q[w];
                     waiter_q.delete(w);
                     ready_insert(s);
                  end
                  switch_to_head();
               end
            end
         end
         default: begin
            if (tgt < -1) begin
               o.status = pts_pkg::RS_UNSUPPORTED;
            end else begin
               z = -1;
               for (int i = 0; i < zombie_q.size(); i++) begin
                  s = zombie_q[i];
                  if (z < 0 && ((tgt == -1) ? (sh_parent[s] == int'(sh_id[c]))
                                            : (int'(sh_id[s]) == tgt))) z = i;
               end
               if (z >= 0) begin
                  s = zombie_q[z];
                  zombie_q.delete(z);
                  o.returned_pid = sh_id[s];
                  o.wait_status = 16'(sh_code[s]) << pts_pkg::CodeShift;
                  sh_state[s] = pts_pkg::ST_FREE;
               end else if (r.no_hang) begin
                  o.status = pts_pkg::RS_NONE_YET;
               end else if (ready_q.size() == 0) begin
                  o.status = pts_pkg::RS_EMPTY;
               end else begin
                  sh_state[c] = pts_pkg::ST_WAITING;
                  sh_target[c] = tgt;
                  waiter_q.push_back(c);
                  switch_to_head();
                  o.status = pts_pkg::RS_BLOCKED;
               end
            end
         end
      endcase
      o.running_pid = sh_id[cur_slot];
      return o;
   endfunction

   // Valid stays high from one word to the next when no gap is drawn.
   task automatic send_word(input pts_pkg::op_type op, input int prio, input int tgt,
                            input int code, input bit nh);
      pts_pkg::req_type r;
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.operation = op;
      r.priority_req = prio[15:0];
      r.target_pid = tgt[15:0];
      r.exit_code = code[7:0];
      r.no_hang = nh;
      req <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_words.push_back(schedule(r));
   endtask

   // Random draw of a field value, biased to the edges.
   function automatic int any_prio();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         2: return -32767;
         3: return $urandom_range(0, 65535) - 32768;
         default: return $urandom_range(0, 6) - 3;
      endcase
   endfunction

   function automatic int live_id();
      int cand[$];
      for (int i = 0; i < NTasks; i++)
         if (sh_state[i] != pts_pkg::ST_FREE) cand.push_back(int'(sh_id[i]));
      return cand[$urandom_range(0, cand.size() - 1)];
   endfunction

   task automatic test_directed();
      send_word(pts_pkg::OP_WAIT, 0, -1, 0, 1'b1);
      send_word(pts_pkg::OP_EXIT, 0, 0, 8'h55, 1'b0);
      send_word(pts_pkg::OP_WAIT, 0, -2, 0, 1'b0);
      send_word(pts_pkg::OP_WAIT, 0, -32768, 0, 1'b0);
      send_word(pts_pkg::OP_START, 32767, 0, 0, 1'b0);
      send_word(pts_pkg::OP_START, -32768, 0, 0, 1'b0);
      send_word(pts_pkg::OP_START, 32767, 0, 0, 1'b0);
      send_word(pts_pkg::OP_YIELD, 0, 0, 0, 1'b0);
      send_word(pts_pkg::OP_WAIT, 0, 0, 0, 1'b1);
      send_word(pts_pkg::OP_EXIT, 0, 0, 8'hff, 1'b0);
      send_word(pts_pkg::OP_WAIT, 0, 2, 0, 1'b0);
      send_word(pts_pkg::OP_WAIT, 0, -1, 0, 1'b0);
      send_word(pts_pkg::OP_EXIT, 0, 0, 8'h00, 1'b0);
      send_word(pts_pkg::OP_WAIT, 0, 32767, 0, 1'b1);
      send_word(pts_pkg::OP_WAIT, 0, -1, 0, 1'b0);
      send_word(pts_pkg::OP_YIELD, 0, 0, 0, 1'b0);
      send_word(pts_pkg::OP_YIELD, 0, 0, 0, 1'b0);
      send_word(pts_pkg::OP_EXIT, 0, 0, 8'haa, 1'b0);
      send_word(pts_pkg::OP_YIELD, 0, 0, 0, 1'b0);
   endtask

   task automatic test_full_table();
      // Fill every slot so the no-free-slot answer shows up, then drain.
      for (int i = 0; i < NTasks + 1; i++)
         send_word(pts_pkg::OP_START, any_prio(), 0, 0, 1'b0);
      for (int i = 0; i < 3 * NTasks; i++)
         send_word(($urandom_range(0, 1) == 0) ? pts_pkg::OP_EXIT : pts_pkg::OP_YIELD, 0, 0,
                   $urandom_range(0, 255), 1'b0);
   endtask

   task automatic test_random(input int count);
      int k;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 99);
         if (k < 28)
            send_word(pts_pkg::OP_START, any_prio(), $urandom_range(0, 65535) - 32768,
                      $urandom_range(0, 255), $urandom_range(0, 1));
         else if (k < 50)
            send_word(pts_pkg::OP_EXIT, any_prio(), $urandom_range(0, 65535) - 32768,
                      $urandom_range(0, 255), $urandom_range(0, 1));
         else if (k < 62)
            send_word(pts_pkg::OP_YIELD, any_prio(), $urandom_range(0, 65535) - 32768,
                      $urandom_range(0, 255), $urandom_range(0, 1));
         else if (k < 80)
            send_word(pts_pkg::OP_WAIT, any_prio(), -1, $urandom_range(0, 255),
                      $urandom_range(0, 3) == 0);
         else if (k < 94)
            send_word(pts_pkg::OP_WAIT, any_prio(), live_id(), $urandom_range(0, 255),
                      $urandom_range(0, 3) == 0);
         else
            send_word(pts_pkg::OP_WAIT, any_prio(), $urandom_range(0, 65535) - 32768,
                      $urandom_range(0, 255), $urandom_range(0, 1));
      end
   endtask

   // Response side: random stalls, in-order compare.
   initial begin
      int hold;
      pts_pkg::rsp_type want;
      @(negedge reset);
      forever begin
         hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (expected_words.size() == 0) begin
            report("unexpected response word", 16'd1, 16'd0);
         end else begin
            want = expected_words.pop_front();
            if (rsp.status !== want.status) report("status", rsp.status, want.status);
            if (rsp.running_pid !== want.running_pid)
               report("running_pid", rsp.running_pid, want.running_pid);
            if (rsp.returned_pid !== want.returned_pid)
               report("returned_pid", rsp.returned_pid, want.returned_pid);
            if (rsp.wait_status !== want.wait_status)
               report("wait_status", rsp.wait_status, want.wait_status);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == StallLimit) begin
         $display("priority_task_scheduler_top_test NOT OK");
         $finish;
      end
   end

   initial begin
      shadow_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_random(1200);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("priority_task_scheduler_top_test OK");
      end else begin
         $display("priority_task_scheduler_top_test NOT OK");
      end
      $finish;
   end
endmodule
